@@ hdl/lwkr_pkg.sv @@
// shared constants, result type and saturation helper for the longest window core
package lwkr_pkg;

    localparam int MAX_LEN     = 1024;
    localparam int ALPHABET    = 26;
    localparam int LETTER_W    = 5;
    localparam int K_W         = 11;
    localparam int LEN_W       = 11;
    localparam int POS_W       = $clog2(MAX_LEN + 1);
    localparam int ADDR_W      = $clog2(MAX_LEN);
    localparam int IDX_W       = $clog2(ALPHABET);
    localparam int SUM_W       = ((POS_W > K_W) ? POS_W : K_W) + 1;
    localparam int OUT_MAX     = (1 << LEN_W) - 1;
    localparam int IN_TDATA_W  = 8;
    localparam int OUT_TDATA_W = 16;

    // one result, best_length in the low bits
    typedef struct packed {
        logic             overflow;
        logic [LEN_W-1:0] best_length;
    } result_t;

    // clamp a window length to the output field
    function automatic logic [LEN_W-1:0] sat_len(input logic [POS_W-1:0] v);
        if (32'(v) > 32'(OUT_MAX))
        begin
            return LEN_W'(OUT_MAX);
        end
        return LEN_W'(v);
    endfunction

endpackage

@@ hdl/lwkr_window_ram.sv @@
// simple dual-port ram with registered read data, read-first
module lwkr_window_ram #(
    parameter int  DEPTH  = 1024,
    parameter int  WIDTH  = 5,
    localparam int ADDR_W = $clog2(DEPTH)
) (
    input  logic              clk,
    input  logic              wr_en,
    input  logic [ADDR_W-1:0] wr_addr,
    input  logic [WIDTH-1:0]  wr_data,
    input  logic [ADDR_W-1:0] rd_addr,
    output logic [WIDTH-1:0]  rd_data
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rd_data_reg;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem_reg[wr_addr] <= wr_data;
        end
        rd_data_reg <= mem_reg[rd_addr];
    end

    assign rd_data = rd_data_reg;

endmodule

@@ hdl/lwkr_out_skid.sv @@
// output register with one skid entry for the result channel
module lwkr_out_skid (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              in_valid,
    output logic              in_ready,
    input  lwkr_pkg::result_t in_data,
    output logic              out_valid,
    input  logic              out_ready,
    output lwkr_pkg::result_t out_data
);

    logic              out_valid_reg, out_valid_next;
    logic              sk_valid_reg, sk_valid_next;
    lwkr_pkg::result_t out_data_reg, out_data_next;
    lwkr_pkg::result_t sk_data_reg, sk_data_next;

    assign in_ready = !sk_valid_reg;

    always_comb
    begin
        out_valid_next = out_valid_reg;
        out_data_next  = out_data_reg;
        sk_valid_next  = sk_valid_reg;
        sk_data_next   = sk_data_reg;
        if (!out_valid_reg || out_ready)
        begin
            // output slot frees up: refill from skid first, else from input
            if (sk_valid_reg)
            begin
                out_valid_next = 1'b1;
                out_data_next  = sk_data_reg;
                sk_valid_next  = 1'b0;
            end
            else
            begin
                out_valid_next = in_valid;
                out_data_next  = in_data;
            end
        end
        else if (in_valid && !sk_valid_reg)
        begin
            sk_valid_next = 1'b1;
            sk_data_next  = in_data;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
            sk_valid_reg  <= 1'b0;
        end
        else
        begin
            out_valid_reg <= out_valid_next;
            sk_valid_reg  <= sk_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        out_data_reg <= out_data_next;
        sk_data_reg  <= sk_data_next;
    end

    assign out_valid = out_valid_reg;
    assign out_data  = out_data_reg;

endmodule

@@ hdl/longest_window_with_k_replacements_core.sv @@
// top level: longest one-letter window with at most k replacements, streamed
//
// usage
//   input stream: one letter request per beat, letter index 0..25 in
//   s_tdata[4:0]; s_tuser set on the first letter of a new string clears all
//   per-string state before that letter is counted. letters 26..31 are skipped
//   but still answered. letters beyond 1024 in one string set overflow and are
//   otherwise skipped.
//   output stream: one result per input request, best_length in m_tdata[10:0]
//   and overflow in m_tdata[11].
//   k_replacements is written through cfg_we / cfg_wdata while the core idles.
// timing
//   one letter per clock while s_tready stays high; each result lands in the
//   output register or the skid entry. the per-letter loop is combinational:
//   count update, window length compare and the left-edge read of the window
//   ram, whose read address is steered by this cycle's shrink decision.
// reset and stall
//   rst_n clears counts, positions, k and the output path; no clearing pass is
//   needed, so the core takes requests right after reset. when m_tready is low
//   an output register and one skid entry hold results, and s_tready drops
//   only once both are full.
module longest_window_with_k_replacements_core (
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             s_tvalid,
    output logic                             s_tready,
    input  logic [lwkr_pkg::IN_TDATA_W-1:0]  s_tdata,   // [4:0] letter
    input  logic                             s_tuser,   // [0] first
    output logic                             m_tvalid,
    input  logic                             m_tready,
    output logic [lwkr_pkg::OUT_TDATA_W-1:0] m_tdata,   // [10:0] best_length, [11] overflow
    input  logic                             cfg_we,
    input  logic [lwkr_pkg::K_W-1:0]         cfg_wdata
);

    localparam int POS_W    = lwkr_pkg::POS_W;
    localparam int ADDR_W   = lwkr_pkg::ADDR_W;
    localparam int IDX_W    = lwkr_pkg::IDX_W;
    localparam int SUM_W    = lwkr_pkg::SUM_W;
    localparam int LETTER_W = lwkr_pkg::LETTER_W;
    localparam int RES_W    = $bits(lwkr_pkg::result_t);

    // configuration
    logic [lwkr_pkg::K_W-1:0] k_reg;

    // per-string state
    logic [POS_W-1:0]    left_reg, left_next;
    logic [POS_W-1:0]    right_reg, right_next;
    logic [POS_W-1:0]    top_reg, top_next;
    logic [POS_W-1:0]    best_reg, best_next;
    logic                ovf_reg, ovf_next;
    logic [POS_W-1:0]    cnt_reg [lwkr_pkg::ALPHABET];
    logic [POS_W-1:0]    cnt_next [lwkr_pkg::ALPHABET];
    // letter at the left edge of the window
    logic [LETTER_W-1:0] head_reg, head_next;
    // forwarding for the ram read of left+1
    logic                byp_reg, byp_next;
    logic [LETTER_W-1:0] byp_data_reg;

    // request decode
    logic                acc;
    logic                clr;
    logic [LETTER_W-1:0] ltr;
    logic                valid_ltr;
    logic [IDX_W-1:0]    ltr_idx;

    // effective state after an optional clear
    logic [POS_W-1:0]    left_e, right_e, top_e, best_e;
    logic                ovf_e;

    logic                do_write;
    logic [POS_W-1:0]    cnt_cur, cnt_inc;
    logic [POS_W-1:0]    win_len, fin_len;
    logic                shrink;
    logic [LETTER_W-1:0] ram_q;
    logic [LETTER_W-1:0] nxt_letter;
    logic [ADDR_W-1:0]   rd_addr;
    logic [ADDR_W-1:0]   wr_addr;

    lwkr_pkg::result_t   res;
    lwkr_pkg::result_t   out_res;

    assign acc       = s_tvalid && s_tready;
    assign ltr       = s_tdata[LETTER_W-1:0];
    assign clr       = acc && s_tuser;
    assign valid_ltr = (32'(ltr) < 32'(lwkr_pkg::ALPHABET));
    assign ltr_idx   = valid_ltr ? ltr[IDX_W-1:0] : '0;

    assign left_e  = clr ? '0 : left_reg;
    assign right_e = clr ? '0 : right_reg;
    assign top_e   = clr ? '0 : top_reg;
    assign best_e  = clr ? '0 : best_reg;
    assign ovf_e   = clr ? 1'b0 : ovf_reg;

    // ram data is window[left+1] unless it was written in the last cycle
    assign nxt_letter = byp_reg ? byp_data_reg : ram_q;

    always_comb
    begin
        do_write = acc && valid_ltr && (32'(right_e) < 32'(lwkr_pkg::MAX_LEN));
        ovf_next = ovf_e;
        if (acc && valid_ltr && !do_write)
        begin
            ovf_next = 1'b1;
        end

        cnt_cur = (clr || !valid_ltr) ? '0 : cnt_reg[ltr_idx];
        cnt_inc = cnt_cur + POS_W'(1);

        top_next = top_e;
        if (do_write && (cnt_inc > top_e))
        begin
            top_next = cnt_inc;
        end

        right_next = do_write ? right_e + POS_W'(1) : right_e;
        win_len    = right_next - left_e;
        // the max count never falls, so one left step is always enough
        shrink     = do_write &&
                     (SUM_W'(win_len) > (SUM_W'(top_next) + SUM_W'(k_reg)));
        left_next  = shrink ? left_e + POS_W'(1) : left_e;
        fin_len    = shrink ? win_len - POS_W'(1) : win_len;

        best_next = best_e;
        if (do_write && (fin_len > best_e))
        begin
            best_next = fin_len;
        end

        // left edge letter: step to left+1, or take the letter written now
        head_next = head_reg;
        if (shrink)
        begin
            head_next = (right_e == left_e + POS_W'(1)) ? ltr : nxt_letter;
        end
        else if (do_write && (right_e == left_e))
        begin
            head_next = ltr;
        end

        rd_addr  = ADDR_W'(left_next + POS_W'(1));
        wr_addr  = ADDR_W'(right_e);
        byp_next = do_write && (right_e == left_next + POS_W'(1));

        // counts: bump the new letter, drop the one leaving on the left
        for (int i = 0; i < lwkr_pkg::ALPHABET; i++)
        begin
            cnt_next[i] = clr ? '0 : cnt_reg[i];
            if (do_write && (ltr_idx == IDX_W'(i)))
            begin
                cnt_next[i] = cnt_next[i] + POS_W'(1);
            end
            if (shrink && (head_reg == LETTER_W'(i)) && (cnt_next[i] != '0))
            begin
                cnt_next[i] = cnt_next[i] - POS_W'(1);
            end
        end

        res.best_length = lwkr_pkg::sat_len(best_next);
        res.overflow    = ovf_next;
    end

    lwkr_window_ram #(
        .DEPTH (lwkr_pkg::MAX_LEN),
        .WIDTH (LETTER_W)
    ) u_window_ram (
        .clk     (clk),
        .wr_en   (do_write),
        .wr_addr (wr_addr),
        .wr_data (ltr),
        .rd_addr (rd_addr),
        .rd_data (ram_q)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            k_reg     <= '0;
            left_reg  <= '0;
            right_reg <= '0;
            top_reg   <= '0;
            best_reg  <= '0;
            ovf_reg   <= 1'b0;
            byp_reg   <= 1'b0;
            for (int i = 0; i < lwkr_pkg::ALPHABET; i++)
            begin
                cnt_reg[i] <= '0;
            end
        end
        else
        begin
            if (cfg_we)
            begin
                k_reg <= cfg_wdata;
            end
            byp_reg <= byp_next;
            if (acc)
            begin
                left_reg  <= left_next;
                right_reg <= right_next;
                top_reg   <= top_next;
                best_reg  <= best_next;
                ovf_reg   <= ovf_next;
                for (int i = 0; i < lwkr_pkg::ALPHABET; i++)
                begin
                    cnt_reg[i] <= cnt_next[i];
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        byp_data_reg <= ltr;
        head_reg     <= head_next;
    end

    // result path: output register plus skid entry
    lwkr_out_skid u_out_skid (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (acc),
        .in_ready  (s_tready),
        .in_data   (res),
        .out_valid (m_tvalid),
        .out_ready (m_tready),
        .out_data  (out_res)
    );

    assign m_tdata = {{(lwkr_pkg::OUT_TDATA_W - RES_W){1'b0}}, out_res};

`ifndef SYNTHESIS
    // window edges never cross
    a_left_le_right: assert property (@(posedge clk) disable iff (!rst_n)
        left_reg <= right_reg)
        else $error("left edge passed right edge");

    // the top count can never exceed the letters taken
    a_top_le_right: assert property (@(posedge clk) disable iff (!rst_n)
        top_reg <= right_reg)
        else $error("top count above string length");

    // best length only grows within one string
    a_best_monotone: assert property (@(posedge clk) disable iff (!rst_n)
        (acc && !s_tuser) |=> (best_reg >= $past(best_reg)))
        else $error("best length fell within a string");

    // input backpressure only while a result is held
    a_stall_needs_result: assert property (@(posedge clk) disable iff (!rst_n)
        !s_tready |-> m_tvalid)
        else $error("input stalled with no result pending");
`endif

endmodule

@@ test/window_result_checker.sv @@
`timescale 1ns / 1ps
// checker for the longest window core: predicts each result and compares it
module window_result_checker (
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             s_tvalid,
    input  logic                             s_tready,
    input  logic [lwkr_pkg::IN_TDATA_W-1:0]  s_tdata,
    input  logic                             s_tuser,
    input  logic                             m_tvalid,
    input  logic                             m_tready,
    input  logic [lwkr_pkg::OUT_TDATA_W-1:0] m_tdata,
    input  logic                             cfg_we,
    input  logic [lwkr_pkg::K_W-1:0]         cfg_wdata,
    output int                               mismatches,
    output int                               outstanding
);

    // predictor copy of the per-string window state
    logic [lwkr_pkg::K_W-1:0]      k_limit;
    logic [lwkr_pkg::LEN_W-1:0]    letter_tally [lwkr_pkg::ALPHABET];
    logic [lwkr_pkg::LETTER_W-1:0] window_ram [lwkr_pkg::MAX_LEN];
    logic [lwkr_pkg::POS_W-1:0]    left_edge;
    logic [lwkr_pkg::POS_W-1:0]    right_edge;
    logic [lwkr_pkg::LEN_W-1:0]    peak_tally;
    logic [lwkr_pkg::LEN_W-1:0]    best_span;
    logic                          string_overflow;

    lwkr_pkg::result_t awaited_results[$];

    function automatic void clear_string();
        for (int i = 0; i < lwkr_pkg::ALPHABET; i++)
        begin
            letter_tally[i] = '0;
        end
        left_edge       = '0;
        right_edge      = '0;
        peak_tally      = '0;
        best_span       = '0;
        string_overflow = 1'b0;
    endfunction

    // one letter request in, the best window length and overflow flag out
    function automatic lwkr_pkg::result_t next_best_window(
        input logic [lwkr_pkg::LETTER_W-1:0] letter,
        input logic                          first);
        logic [lwkr_pkg::LETTER_W-1:0] gone;
        logic [lwkr_pkg::POS_W-1:0]    span;
        lwkr_pkg::result_t             r;
        if (first)
        begin
            clear_string();
        end
        if (int'(letter) < lwkr_pkg::ALPHABET)
        begin
            if (int'(right_edge) >= lwkr_pkg::MAX_LEN)
            begin
                string_overflow = 1'b1;
            end
            else
            begin
                window_ram[right_edge[lwkr_pkg::ADDR_W-1:0]] = letter;
                letter_tally[letter] = letter_tally[letter] + 1'b1;
                if (letter_tally[letter] > peak_tally)
                begin
                    peak_tally = letter_tally[letter];
                end
                right_edge = right_edge + 1'b1;
                span = right_edge - left_edge;
                // at most one shrink, the peak count never drops
                if (int'(span) > int'(peak_tally) + int'(k_limit) &&
                    int'(left_edge) < lwkr_pkg::MAX_LEN)
                begin
                    gone = window_ram[left_edge[lwkr_pkg::ADDR_W-1:0]];
                    if (letter_tally[gone] != 0)
                    begin
                        letter_tally[gone] = letter_tally[gone] - 1'b1;
                    end
                    left_edge = left_edge + 1'b1;
                    span = span - 1'b1;
                end
                if (int'(span) > int'(best_span))
                begin
                    best_span = lwkr_pkg::LEN_W'(span);
                end
            end
        end
        r.best_length = best_span;
        r.overflow    = string_overflow;
        return r;
    endfunction

    always @(posedge clk or negedge rst_n)
    begin
        lwkr_pkg::result_t seen;
        lwkr_pkg::result_t want;
        if (!rst_n)
        begin
            clear_string();
            k_limit    = '0;
            mismatches = 0;
            awaited_results.delete();
        end
        else
        begin
            if (cfg_we)
            begin
                k_limit = cfg_wdata;
            end
            if (s_tvalid && s_tready)
            begin
                awaited_results.push_back(
                    next_best_window(s_tdata[lwkr_pkg::LETTER_W-1:0], s_tuser));
            end
            if (m_tvalid && m_tready)
            begin
                seen = lwkr_pkg::result_t'(m_tdata[lwkr_pkg::LEN_W:0]);
                if (awaited_results.size() == 0)
                begin
                    mismatches++;
                    $display("%0t unexpected result: expected none, got best_length %0d overflow %0d",
                             $time, seen.best_length, seen.overflow);
                end
                else
                begin
                    want = awaited_results.pop_front();
                    if (seen.best_length !== want.best_length)
                    begin
                        mismatches++;
                        $display("%0t best_length mismatch: expected %0d, got %0d",
                                 $time, want.best_length, seen.best_length);
                    end
                    if (seen.overflow !== want.overflow)
                    begin
                        mismatches++;
                        $display("%0t overflow mismatch: expected %0d, got %0d",
                                 $time, want.overflow, seen.overflow);
                    end
                end
            end
        end
        outstanding = awaited_results.size();
    end

endmodule

@@ test/tb_top.sv @@
`timescale 1ns / 1ps
// testbench top for the longest window core: stimulus, stalls and verdict
module tb_top;

    // generous bound: ~550 requests, each worst case a long sender gap plus a long receiver stall
    localparam int CYCLE_LIMIT  = 500000;
    // receiver hold-off, far longer than the output register plus skid entry
    localparam int LONG_HOLD    = 200;
    // minimum random requests per phase, seven phases
    localparam int PHASE_ITEMS  = 65;

    logic                             clk;
    logic                             rst_n     = 1'b0;
    logic                             s_tvalid  = 1'b0;
    logic                             s_tready;
    logic [lwkr_pkg::IN_TDATA_W-1:0]  s_tdata   = '0;     // [4:0] letter
    logic                             s_tuser   = 1'b0;   // [0] first
    logic                             m_tvalid;
    logic                             m_tready  = 1'b0;
    logic [lwkr_pkg::OUT_TDATA_W-1:0] m_tdata;            // [10:0] best_length, [11] overflow
    logic                             cfg_we    = 1'b0;
    logic [lwkr_pkg::K_W-1:0]         cfg_wdata = '0;

    int mismatches;
    int outstanding;

    // idle behavior knobs, written only by the stimulus process; cycles is counted by the watchdog
    int tx_mode    = 0;
    int rx_mode    = 0;
    int hold_asked = 0;
    int cycles     = 0;

    longest_window_with_k_replacements_core dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .cfg_we    (cfg_we),
        .cfg_wdata (cfg_wdata)
    );

    window_result_checker u_checker (
        .clk         (clk),
        .rst_n       (rst_n),
        .s_tvalid    (s_tvalid),
        .s_tready    (s_tready),
        .s_tdata     (s_tdata),
        .s_tuser     (s_tuser),
        .m_tvalid    (m_tvalid),
        .m_tready    (m_tready),
        .m_tdata     (m_tdata),
        .cfg_we      (cfg_we),
        .cfg_wdata   (cfg_wdata),
        .mismatches  (mismatches),
        .outstanding (outstanding)
    );

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    // watchdog: a hang or a lost result ends here
    initial
    begin
        while (cycles < CYCLE_LIMIT)
        begin
            @(posedge clk);
            cycles++;
        end
        $display("simulation failed");
        $finish;
    end

    // mostly short gaps, now and then a long one
    function automatic int gap_len();
        if ($urandom_range(0, 9) == 0)
        begin
            return $urandom_range(8, 40);
        end
        return $urandom_range(1, 3);
    endfunction

    // receiver: random stalls per rx_mode, plus a long hold-off when asked
    initial
    begin
        int stall_left;
        int hold_seen;
        stall_left = 0;
        hold_seen  = 0;
        forever
        begin
            @(posedge clk);
            if (hold_seen != hold_asked)
            begin
                // hold off long enough for the core to fill up and drop s_tready
                hold_seen = hold_asked;
                m_tready <= 1'b0;
                repeat (LONG_HOLD) @(posedge clk);
            end
            else if (stall_left > 0)
            begin
                m_tready <= 1'b0;
                stall_left--;
            end
            else
            begin
                m_tready <= 1'b1;
                if (rx_mode != 0 && $urandom_range(0, 3) == 0)
                begin
                    stall_left = gap_len();
                end
            end
        end
    end

    // offer one letter request and wait for it to be taken; valid stays high
    // when no gap follows so back-to-back requests stream at full rate
    task automatic send_letter(input logic [lwkr_pkg::LETTER_W-1:0] letter, input logic first);
        s_tvalid <= 1'b1;
        s_tdata  <= lwkr_pkg::IN_TDATA_W'(letter);
        s_tuser  <= first;
        @(posedge clk);
        while (!s_tready)
        begin
            @(posedge clk);
        end
        if (tx_mode != 0 && $urandom_range(0, 2) == 0)
        begin
            s_tvalid <= 1'b0;
            repeat (gap_len()) @(posedge clk);
        end
    endtask

    // wait at negedge until every expected result is back, then let the
    // output register and skid entry settle before touching k
    task automatic drain();
        @(negedge clk);
        while (outstanding != 0)
        begin
            @(negedge clk);
        end
        repeat (4) @(posedge clk);
    endtask

    task automatic write_k(input logic [lwkr_pkg::K_W-1:0] value);
        cfg_we    <= 1'b1;
        cfg_wdata <= value;
        @(posedge clk);
        cfg_we    <= 1'b0;
    endtask

    // one string: letters drawn from a narrow or wide span of the alphabet so
    // repeats are common, a few skipped codes 26..31 mixed in as noise
    task automatic send_string(input int count, input bit fresh);
        int base;
        int spread;
        logic [lwkr_pkg::LETTER_W-1:0] letter;
        base   = $urandom_range(0, lwkr_pkg::ALPHABET - 1);
        spread = ($urandom_range(0, 1) == 0) ? $urandom_range(1, 3)
                                             : $urandom_range(1, lwkr_pkg::ALPHABET);
        for (int i = 0; i < count; i++)
        begin
            if ($urandom_range(0, 19) == 0)
            begin
                letter = lwkr_pkg::LETTER_W'($urandom_range(lwkr_pkg::ALPHABET, 31));
            end
            else
            begin
                letter = lwkr_pkg::LETTER_W'((base + $urandom_range(0, spread - 1))
                                             % lwkr_pkg::ALPHABET);
            end
            send_letter(letter, fresh && i == 0);
        end
    endtask

    // one configuration phase: idle core, new k, then random strings
    task automatic run_phase(input logic [lwkr_pkg::K_W-1:0] k_value, input int tx,
                             input int rx, input bit long_hold);
        int sent;
        int count;
        drain();
        tx_mode = tx;
        rx_mode = rx;
        write_k(k_value);
        if (long_hold)
        begin
            hold_asked++;
        end
        sent = 0;
        while (sent < PHASE_ITEMS)
        begin
            count = ($urandom_range(0, 9) == 0) ? $urandom_range(25, 60)
                                                : $urandom_range(1, 24);
            // mostly fresh strings, sometimes a continuation of the last one
            send_string(count, $urandom_range(0, 9) != 0);
            sent += count;
        end
        s_tvalid <= 1'b0;
    endtask

    initial
    begin
        repeat (5) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed requests with k at its reset value of zero, full rate
        send_letter(lwkr_pkg::LETTER_W'(0), 1'b1);     // first letter of a string
        send_letter(lwkr_pkg::LETTER_W'(25), 1'b0);    // highest letter, window shrinks
        send_letter(lwkr_pkg::LETTER_W'(25), 1'b0);
        send_letter(lwkr_pkg::LETTER_W'(25), 1'b0);
        send_letter(lwkr_pkg::LETTER_W'(0), 1'b0);
        send_letter(lwkr_pkg::LETTER_W'(31), 1'b0);    // skipped code, result repeats
        send_letter(lwkr_pkg::LETTER_W'(26), 1'b1);    // skipped code with first: still clears
        send_letter(lwkr_pkg::LETTER_W'(5), 1'b0);
        send_letter(lwkr_pkg::LETTER_W'(5), 1'b0);
        send_letter(lwkr_pkg::LETTER_W'(30), 1'b0);
        send_letter(lwkr_pkg::LETTER_W'(5), 1'b0);
        // walk each letter bit
        send_letter(lwkr_pkg::LETTER_W'(1), 1'b1);
        send_letter(lwkr_pkg::LETTER_W'(2), 1'b0);
        send_letter(lwkr_pkg::LETTER_W'(4), 1'b0);
        send_letter(lwkr_pkg::LETTER_W'(8), 1'b0);
        send_letter(lwkr_pkg::LETTER_W'(16), 1'b0);
        send_letter(lwkr_pkg::LETTER_W'(15), 1'b0);
        send_letter(lwkr_pkg::LETTER_W'(0), 1'b0);
        send_letter(lwkr_pkg::LETTER_W'(25), 1'b0);
        send_letter(lwkr_pkg::LETTER_W'(0), 1'b1);
        send_letter(lwkr_pkg::LETTER_W'(0), 1'b0);
        s_tvalid <= 1'b0;

        run_phase(lwkr_pkg::K_W'(0), 0, 0, 1'b0);        // no idling at all
        run_phase(lwkr_pkg::K_W'(1), 1, 1, 1'b0);
        run_phase(lwkr_pkg::K_W'(2), 0, 1, 1'b1);        // long receiver hold, sender keeps offering
        run_phase(lwkr_pkg::K_W'(5), 1, 0, 1'b0);
        run_phase(lwkr_pkg::K_W'($urandom_range(3, 20)), 1, 1, 1'b0);
        run_phase(lwkr_pkg::K_W'($urandom_range(0, 1024)), 1, 1, 1'b0);
        // k at the string length limit
        run_phase(lwkr_pkg::K_W'(1024), 1, 1, 1'b0);

        drain();
        if (mismatches == 0)
        begin
            $display("simulation ok");
        end
        else
        begin
            $display("simulation failed");
        end
        $finish;
    end

endmodule
